// File: rtl/lcbe_pkg.sv
// ----------------------------------------------------------------------------
// LED color buffer engine package
// Shared constants, command codes and controller states.
// ----------------------------------------------------------------------------
package lcbe_pkg;

  localparam int unsigned MAX_LEDS   = 256;
  localparam int unsigned MAX_COLORS = 4;

  localparam logic [7:0] BYTE_MAX        = 8'd255;
  localparam logic       SHIFT_ZERO_FILL = 1'b0;

  typedef enum logic [2:0] {
    ACT_WRITE    = 3'd0,
    ACT_READ     = 3'd1,
    ACT_FILL     = 3'd2,
    ACT_FADE_OUT = 3'd3,
    ACT_FADE_IN  = 3'd4,
    ACT_SHIFT    = 3'd5,
    ACT_POWER    = 3'd6
  } action_e;

  typedef enum logic {
    REG_LED_COUNT = 1'b0,
    REG_COLORS    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SPREP,
    ST_RD,
    ST_WR,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

// File: rtl/lcbe_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module lcbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lcbe_div.sv
// ----------------------------------------------------------------------------
// Byte divider
// Restoring division of an 8-bit value by a 16-bit divisor, one quotient bit
// per cycle. The divisor must stay stable while the division runs.
// ----------------------------------------------------------------------------
module lcbe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [7:0]  dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [7:0]  quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_q[7]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      quo_d  = dividend_i;
      rem_d  = 16'd0;
    end else if (busy_q) begin
      rem_d = fits ? 16'(trial - {1'b0, divisor_i}) : trial[15:0];
      quo_d = {quo_q[6:0], fits};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/led_color_buffer_engine.sv
// ----------------------------------------------------------------------------
// LED color buffer engine
// Byte store of LED color channels with write, read, fill, fade, shift and
// brightness total commands, one result per command.
// ----------------------------------------------------------------------------
// After reset the store is cleared by a pass over all MAX_LEDS*MAX_COLORS
// bytes (1024 by default) before the first request is taken. Commands then
// run one at a time over single-port store and scratch memories, so each
// stored byte takes a read step (ST_RD) and then a write step (ST_WR). A
// write or read covers the colors of one LED; fill, fade in, fade out and
// power total cover colors_per_led bytes of each of led_count LEDs. Fade out
// also waits on the bit-serial divider for each byte; a shift first copies
// its range to scratch and then moves it back. Errors go straight to the
// result state (ST_FIN) without a byte pass.
module led_color_buffer_engine #(
  parameter int unsigned MAX_LEDS   = lcbe_pkg::MAX_LEDS,
  parameter int unsigned MAX_COLORS = lcbe_pkg::MAX_COLORS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        action_i,
  input  logic [8:0]        led_index_i,
  input  logic [7:0]        color_0_i,
  input  logic [7:0]        color_1_i,
  input  logic [7:0]        color_2_i,
  input  logic [7:0]        color_3_i,
  input  logic [15:0]       factor_i,
  input  logic signed [9:0] shift_amount_i,
  input  logic              circular_shift_i,
  input  logic signed [9:0] range_first_i,
  input  logic signed [9:0] range_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              status_o,
  output logic [7:0]        read_0_o,
  output logic [7:0]        read_1_o,
  output logic [7:0]        read_2_o,
  output logic [7:0]        read_3_o,
  output logic [17:0]       brightness_total_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [8:0]        cfg_data_i
);

  localparam int unsigned DEPTH = MAX_LEDS * MAX_COLORS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned LW    = $clog2(MAX_LEDS + 1);
  localparam int unsigned NW    = (LW > 9) ? LW : 9;
  localparam int unsigned SW    = NW + 2;
  localparam logic signed [SW-1:0] ZERO_S = '0;
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);

  function automatic logic [NW+2:0] mul_cpl(input logic [NW-1:0] a, input logic [2:0] c);
    mul_cpl = {3'b000, a} * {{NW{1'b0}}, c};
  endfunction

  lcbe_pkg::state_e state_q, state_d;

  logic [8:0]  led_count_q;
  logic [2:0]  colors_q;
  logic [AW-1:0] clr_q, clr_d;
  logic        out_valid_q, out_valid_d;

  logic [2:0]  action_q, action_d;
  logic [8:0]  idx_q, idx_d;
  logic [7:0]  col_q [4];
  logic [7:0]  col_d [4];
  logic [15:0] factor_q, factor_d;
  logic signed [9:0] amount_q, amount_d;
  logic        circ_q, circ_d;
  logic signed [9:0] first_q, first_d;
  logic signed [9:0] last_q, last_d;

  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] sb_q, sb_d;
  logic [CW-1:0] j_q, j_d;
  logic [1:0]  ch_q, ch_d;
  logic        phase_q, phase_d;
  logic        pos_q, pos_d;
  logic        zero_q, zero_d;
  logic signed [SW-1:0] start_q, start_d;
  logic signed [SW-1:0] end_q, end_d;
  logic        status_q, status_d;
  logic [7:0]  rd_q [4];
  logic [7:0]  rd_d [4];
  logic [17:0] total_q, total_d;

  logic        ostatus_q, ostatus_d;
  logic [7:0]  ord_q [4];
  logic [7:0]  ord_d [4];
  logic [17:0] ototal_q, ototal_d;

  logic [NW-1:0] n_eff;
  logic [2:0]    cpl_eff;
  logic [NW+2:0] cells_w;
  logic [CW-1:0] cells;
  logic [AW-1:0] rw_base;

  logic signed [SW-1:0] f_s, l_s, n_s, rel_f, rel_l, start_c, end_c;
  logic signed [SW-1:0] size_s, amt_s, abs_s;
  logic        shift_ok;

  logic [AW-1:0] addr_s;
  logic [CW-1:0] j_nx, src, rem_len;
  logic        src_zero;
  logic [2:0]  ch_inc;
  logic        step;
  logic [23:0] prod;

  logic          store_we, scr_we;
  logic [AW-1:0] store_addr, scr_addr;
  logic [7:0]    store_wdata, scr_wdata, store_rdata, scr_rdata;
  logic          div_start, div_done;
  logic [7:0]    div_quo;

  lcbe_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .addr_i  (store_addr),
    .wdata_i (store_wdata),
    .rdata_o (store_rdata)
  );

  lcbe_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_scratch (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .addr_i  (scr_addr),
    .wdata_i (scr_wdata),
    .rdata_o (scr_rdata)
  );

  lcbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (store_rdata),
    .divisor_i  (factor_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    if (led_count_q == 9'd0) begin
      n_eff = NW'(1);
    end else if (NW'(led_count_q) > NW'(MAX_LEDS)) begin
      n_eff = NW'(MAX_LEDS);
    end else begin
      n_eff = NW'(led_count_q);
    end
    if (colors_q == 3'd0) begin
      cpl_eff = 3'd1;
    end else if (colors_q > 3'(MAX_COLORS)) begin
      cpl_eff = 3'(MAX_COLORS);
    end else begin
      cpl_eff = colors_q;
    end
  end

  assign cells_w = mul_cpl(n_eff, cpl_eff);
  assign cells   = cells_w[CW-1:0];
  assign rw_base = AW'(mul_cpl(NW'(idx_q - 9'd1), cpl_eff));

  // Shift range ends, then size and acceptance.
  always_comb begin
    f_s = SW'(first_q);
    l_s = SW'(last_q);
    n_s = $signed({2'b00, n_eff});
    rel_f = (f_s < ZERO_S) ? f_s + n_s + ONE_S : f_s;
    rel_l = (l_s < ZERO_S) ? l_s + n_s + ONE_S : l_s;
    if (rel_f < ZERO_S) rel_f = ZERO_S;
    if (rel_l < ZERO_S) rel_l = ZERO_S;
    start_c = ((rel_f < ONE_S) ? ONE_S : rel_f) - ONE_S;
    end_c   = (rel_l > n_s) ? n_s : rel_l;
    size_s  = end_q - start_q;
    amt_s   = SW'(amount_q);
    abs_s   = (amt_s < ZERO_S) ? ZERO_S - amt_s : amt_s;
    shift_ok = (amt_s > ZERO_S - size_s) && (amt_s < size_s);
  end

  assign addr_s  = base_q + j_q[AW-1:0];
  assign j_nx    = j_q + CW'(1);
  assign ch_inc  = {1'b0, ch_q} + 3'd1;
  assign rem_len = len_q - sb_q;
  assign prod    = store_rdata * factor_q;

  always_comb begin
    if (pos_q) begin
      src      = (j_q >= sb_q) ? j_q - sb_q : rem_len + j_q;
      src_zero = (j_q < sb_q) && (circ_q == lcbe_pkg::SHIFT_ZERO_FILL);
    end else begin
      src      = (j_q < rem_len) ? j_q + sb_q : j_q - rem_len;
      src_zero = (j_q >= rem_len) && (circ_q == lcbe_pkg::SHIFT_ZERO_FILL);
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    action_d    = action_q;
    idx_d       = idx_q;
    col_d       = col_q;
    factor_d    = factor_q;
    amount_d    = amount_q;
    circ_d      = circ_q;
    first_d     = first_q;
    last_d      = last_q;
    base_d      = base_q;
    len_d       = len_q;
    sb_d        = sb_q;
    j_d         = j_q;
    ch_d        = ch_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    zero_d      = zero_q;
    start_d     = start_q;
    end_d       = end_q;
    status_d    = status_q;
    rd_d        = rd_q;
    total_d     = total_q;
    ostatus_d   = ostatus_q;
    ord_d       = ord_q;
    ototal_d    = ototal_q;
    store_we    = 1'b0;
    store_addr  = addr_s;
    store_wdata = 8'd0;
    scr_we      = 1'b0;
    scr_addr    = j_q[AW-1:0];
    scr_wdata   = store_rdata;
    div_start   = 1'b0;
    step        = 1'b0;
    in_ready_o  = (state_q == lcbe_pkg::ST_IDLE);

    case (state_q)
      lcbe_pkg::ST_CLEAR: begin
        store_we   = 1'b1;
        store_addr = clr_q;
        clr_d      = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = lcbe_pkg::ST_IDLE;
        end
      end
      lcbe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          action_d = action_i;
          idx_d    = led_index_i;
          col_d[0] = color_0_i;
          col_d[1] = color_1_i;
          col_d[2] = color_2_i;
          col_d[3] = color_3_i;
          factor_d = factor_i;
          amount_d = shift_amount_i;
          circ_d   = circular_shift_i;
          first_d  = range_first_i;
          last_d   = range_last_i;
          state_d  = lcbe_pkg::ST_DECODE;
        end
      end
      lcbe_pkg::ST_DECODE: begin
        status_d = 1'b0;
        rd_d     = '{default: 8'd0};
        total_d  = 18'd0;
        j_d      = '0;
        ch_d     = 2'd0;
        phase_d  = 1'b0;
        base_d   = '0;
        len_d    = cells;
        state_d  = lcbe_pkg::ST_RD;
        case (action_q)
          lcbe_pkg::ACT_WRITE, lcbe_pkg::ACT_READ: begin
            base_d = rw_base;
            len_d  = CW'(cpl_eff);
            if (idx_q == 9'd0 || NW'(idx_q) > n_eff) begin
              status_d = 1'b1;
              state_d  = lcbe_pkg::ST_FIN;
            end
          end
          lcbe_pkg::ACT_FILL, lcbe_pkg::ACT_POWER: begin
          end
          lcbe_pkg::ACT_FADE_OUT, lcbe_pkg::ACT_FADE_IN: begin
            if (factor_q == 16'd0) begin
              status_d = 1'b1;
              state_d  = lcbe_pkg::ST_FIN;
            end
          end
          lcbe_pkg::ACT_SHIFT: begin
            start_d = start_c;
            end_d   = end_c;
            state_d = lcbe_pkg::ST_SPREP;
          end
          default: begin
            status_d = 1'b1;
            state_d  = lcbe_pkg::ST_FIN;
          end
        endcase
      end
      lcbe_pkg::ST_SPREP: begin
        base_d = AW'(mul_cpl(start_q[NW-1:0], cpl_eff));
        len_d  = CW'(mul_cpl(size_s[NW-1:0], cpl_eff));
        sb_d   = CW'(mul_cpl(abs_s[NW-1:0], cpl_eff));
        pos_d  = (amt_s > ZERO_S);
        if (!shift_ok) begin
          status_d = 1'b1;
          state_d  = lcbe_pkg::ST_FIN;
        end else if (amount_q == 10'sd0) begin
          state_d = lcbe_pkg::ST_FIN;
        end else begin
          state_d = lcbe_pkg::ST_RD;
        end
      end
      lcbe_pkg::ST_RD: begin
        zero_d   = src_zero;
        scr_addr = src[AW-1:0];
        state_d  = lcbe_pkg::ST_WR;
      end
      lcbe_pkg::ST_WR: begin
        step = 1'b1;
        case (action_q)
          lcbe_pkg::ACT_WRITE, lcbe_pkg::ACT_FILL: begin
            store_we    = 1'b1;
            store_wdata = col_q[ch_q];
          end
          lcbe_pkg::ACT_READ: begin
            rd_d[ch_q] = store_rdata;
          end
          lcbe_pkg::ACT_FADE_OUT: begin
            div_start = 1'b1;
            step      = 1'b0;
            state_d   = lcbe_pkg::ST_DIV;
          end
          lcbe_pkg::ACT_FADE_IN: begin
            store_we    = 1'b1;
            store_wdata = (prod > 24'(lcbe_pkg::BYTE_MAX)) ? lcbe_pkg::BYTE_MAX : prod[7:0];
          end
          lcbe_pkg::ACT_POWER: begin
            total_d = total_q + 18'(store_rdata);
          end
          lcbe_pkg::ACT_SHIFT: begin
            if (!phase_q) begin
              scr_we = 1'b1;
            end else begin
              store_we    = 1'b1;
              store_wdata = zero_q ? 8'd0 : scr_rdata;
            end
          end
          default: begin
          end
        endcase
      end
      lcbe_pkg::ST_DIV: begin
        if (div_done) begin
          store_we    = 1'b1;
          store_wdata = div_quo;
          step        = 1'b1;
        end
      end
      lcbe_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ostatus_d   = status_q;
          ord_d       = rd_q;
          ototal_d    = total_q;
          state_d     = lcbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcbe_pkg::ST_IDLE;
      end
    endcase

    if (step) begin
      ch_d = (ch_inc == cpl_eff) ? 2'd0 : ch_inc[1:0];
      j_d  = j_nx;
      state_d = lcbe_pkg::ST_RD;
      if (j_nx == len_q) begin
        if (action_q == lcbe_pkg::ACT_SHIFT && !phase_q) begin
          phase_d = 1'b1;
          j_d     = '0;
          ch_d    = 2'd0;
        end else begin
          state_d = lcbe_pkg::ST_FIN;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcbe_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      led_count_q <= 9'd256;
      colors_q    <= 3'd3;
    end else begin
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == lcbe_pkg::REG_LED_COUNT) begin
          led_count_q <= cfg_data_i;
        end else begin
          colors_q <= cfg_data_i[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    action_q  <= action_d;
    idx_q     <= idx_d;
    col_q     <= col_d;
    factor_q  <= factor_d;
    amount_q  <= amount_d;
    circ_q    <= circ_d;
    first_q   <= first_d;
    last_q    <= last_d;
    base_q    <= base_d;
    len_q     <= len_d;
    sb_q      <= sb_d;
    j_q       <= j_d;
    ch_q      <= ch_d;
    phase_q   <= phase_d;
    pos_q     <= pos_d;
    zero_q    <= zero_d;
    start_q   <= start_d;
    end_q     <= end_d;
    status_q  <= status_d;
    rd_q      <= rd_d;
    total_q   <= total_d;
    ostatus_q <= ostatus_d;
    ord_q     <= ord_d;
    ototal_q  <= ototal_d;
  end

  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign status_o           = ostatus_q;
  assign read_0_o           = ord_q[0];
  assign read_1_o           = ord_q[1];
  assign read_2_o           = ord_q[2];
  assign read_3_o           = ord_q[3];
  assign brightness_total_o = ototal_q;

endmodule

// File: rtl/lcbe_checker.sv
// ----------------------------------------------------------------------------
// LED color buffer engine checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lcbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        status_o,
  input logic [7:0]  read_0_o,
  input logic [7:0]  read_1_o,
  input logic [7:0]  read_2_o,
  input logic [7:0]  read_3_o,
  input logic [17:0] brightness_total_o
);

  logic read_zero;

  assign read_zero = (read_0_o == 8'd0) && (read_1_o == 8'd0) &&
                     (read_2_o == 8'd0) && (read_3_o == 8'd0);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result dropped before it was taken.");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> read_zero && brightness_total_o == 18'd0)
    else $error("Failed request returned nonzero data.");

  a_total_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brightness_total_o != 18'd0 |-> read_zero && !status_o)
    else $error("Brightness total mixed with read data.");

  a_busy_before_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("Result appeared while the engine was idle.");

endmodule

bind led_color_buffer_engine lcbe_checker u_lcbe_checker (.*);
